// File: hw/rtl/nacb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nacb_pkg
// Shared types and constants of the nearest-atom Coulomb boundary block.
// ----------------------------------------------------------------------------
package nacb_pkg;

	localparam int MAX_ATOMS = 64;
	localparam int IDX_W     = $clog2(MAX_ATOMS);
	localparam int CNT_W     = $clog2(MAX_ATOMS + 1);

	// request opcodes
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_INSIDE  = 2'd0;
	localparam logic [1:0] STAT_OUTSIDE = 2'd1;
	localparam logic [1:0] STAT_OVERLAP = 2'd2;
	localparam logic [1:0] STAT_EMPTY   = 2'd3;

	// configuration register indexes
	localparam logic CFG_BALL_RADIUS = 1'b0;
	localparam logic CFG_USE_PSEUDO  = 1'b1;

	localparam logic [30:0] BALL_RADIUS_RST = 31'd262144;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [31:0]        node_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0]        nuclear_charge;
		logic [15:0]        valence_charge;
	} req_t;

	typedef struct packed {
		logic [31:0]        result_node;
		logic [1:0]         status;
		logic [5:0]         nearest_atom;
		logic [31:0]        nearest_distance;
		logic signed [31:0] potential;
	} res_t;

	// one stored atom
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [15:0] nuc;
		logic [15:0] val;
	} atom_t;

endpackage

// File: hw/rtl/nearest_atom_coulomb_bin.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_atom_coulomb_bin
// Nearest-atom Coulomb boundary value for mesh nodes.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy rises only when
// the two-entry command queue is full. Clear and append execute as soon as
// they leave the queue. A query on an idle block with N stored atoms passes
// through the scan (one memory read per atom, four-stage distance pipeline
// drain), the bit-serial square root and the restoring divider; inside and
// overlap results, and outside results at zero distance, skip the divider.
// An empty table answers from the idle state without a scan. Requests behind
// a query wait in the queue. Each result appears for exactly one cycle with
// done high and must be captured then. Configuration is written through
// cfg_we / cfg_index / cfg_data.
module nearest_atom_coulomb_bin import nacb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output res_t        res,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data
);

	logic [30:0] ball_radius_q;
	logic        use_pseudo_q;
	logic        q_full, q_valid, push, pop;
	req_t        push_data, q_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ball_radius_q <= BALL_RADIUS_RST;
			use_pseudo_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BALL_RADIUS: ball_radius_q <= cfg_data;
				CFG_USE_PSEUDO:  use_pseudo_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	nacb_front u_front (
		.start     (start),
		.req       (req),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	nacb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.valid     (q_valid),
		.data      (q_data)
	);

	nacb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.pop         (pop),
		.ball_radius (ball_radius_q),
		.use_pseudo  (use_pseudo_q),
		.done        (done),
		.res         (res)
	);

endmodule

// File: hw/rtl/nacb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nacb_front
// Request intake: decodes the opcode, drops unused opcodes and pushes
// real commands into the command queue.
// ----------------------------------------------------------------------------
module nacb_front import nacb_pkg::*; (
	input  logic start,
	input  req_t req,
	input  logic q_full,
	output logic busy,
	output logic push,
	output req_t push_data
);

	logic is_cmd;

	// classify opcode
	always_comb begin
		unique case (req.opcode)
			OP_CLEAR, OP_APPEND, OP_QUERY: is_cmd = 1'b1;
			default:                       is_cmd = 1'b0;
		endcase
	end

	assign busy      = q_full;
	assign push      = start && !q_full && is_cmd;
	assign push_data = req;

endmodule

// File: hw/rtl/nacb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nacb_queue
// Two-entry command queue between intake and execution.
// ----------------------------------------------------------------------------
module nacb_queue import nacb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_data,
	input  logic pop,
	output logic full,
	output logic valid,
	output req_t data
);

	req_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign data  = ent_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_data;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// File: hw/rtl/nacb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nacb_back
// Command execution: atom table, pipelined nearest-atom scan, bit-serial
// square root and restoring divider for the potential.
// ----------------------------------------------------------------------------
module nacb_back import nacb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  req_t        q_data,
	output logic        pop,
	input  logic [30:0] ball_radius,
	input  logic        use_pseudo,
	output logic        done,
	output res_t        res
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SQRT, S_DIV} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q, issue_q;
	req_t              qry_q;
	logic [61:0]       r2_q;
	logic [67:0]       best_q;
	logic [IDX_W-1:0]  best_i_q;
	logic [15:0]       best_c_q;
	logic [1:0]        ins_q;
	logic              done_q;
	res_t              res_q;

	// sqrt / divide state
	logic [63:0] sx_q;
	logic [34:0] srem_q;
	logic [31:0] root_q;
	logic [5:0]  step_q;
	logic        sat_q;
	logic [31:0] dist_q;
	logic [39:0] num_q, quot_q;
	logic [32:0] drem_q;

	atom_t mem [MAX_ATOMS];

	// scan pipeline
	atom_t             rd_s1;
	logic              v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]  idx_s1, idx_s2, idx_s3, idx_s4;
	logic [15:0]       c_s2, c_s3, c_s4;
	logic [32:0]       ax_s2, ay_s2, az_s2;
	logic [65:0]       sqx_s3, sqy_s3, sqz_s3;
	logic [67:0]       sum_s4;

	logic mem_we, issue_go, pipe_empty;

	assign pop        = (state_q == S_IDLE) && q_valid;
	assign mem_we     = pop && (q_data.opcode == OP_APPEND) && (cnt_q < CNT_W'(MAX_ATOMS));
	assign issue_go   = (state_q == S_SCAN) && (issue_q < cnt_q);
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3 && !v_s4;
	assign done       = done_q;
	assign res        = res_q;

	function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
		logic signed [32:0] d;
		d = $signed({a[31], a}) - $signed({b[31], b});
		return d[32] ? 33'(-d) : 33'(d);
	endfunction

	// atom memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[cnt_q[IDX_W-1:0]] <= '{x: q_data.pos_x, y: q_data.pos_y, z: q_data.pos_z,
				nuc: q_data.nuclear_charge, val: q_data.valence_charge};
		rd_s1 <= mem[issue_q[IDX_W-1:0]];
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[IDX_W-1:0];
		ax_s2  <= abs_diff(qry_q.pos_x, rd_s1.x);
		ay_s2  <= abs_diff(qry_q.pos_y, rd_s1.y);
		az_s2  <= abs_diff(qry_q.pos_z, rd_s1.z);
		c_s2   <= use_pseudo ? rd_s1.val : rd_s1.nuc;
		idx_s2 <= idx_s1;
		sqx_s3 <= 66'(ax_s2) * 66'(ax_s2);
		sqy_s3 <= 66'(ay_s2) * 66'(ay_s2);
		sqz_s3 <= 66'(az_s2) * 66'(az_s2);
		c_s3   <= c_s2;
		idx_s3 <= idx_s2;
		sum_s4 <= 68'(sqx_s3) + 68'(sqy_s3) + 68'(sqz_s3);
		c_s4   <= c_s3;
		idx_s4 <= idx_s3;
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue_go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// step logic for root and quotient
	logic [34:0] srem_sh, strial;
	logic [32:0] drem_sh;
	logic [31:0] mag;
	always_comb begin
		srem_sh = {srem_q[32:0], sx_q[63:62]};
		strial  = {1'b0, root_q, 2'b01};
		drem_sh = {drem_q[31:0], num_q[39]};
		mag     = (quot_q > 40'h0080000000) ? 32'h80000000 : quot_q[31:0];
	end

	// control and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			issue_q  <= '0;
			done_q   <= 1'b0;
			ins_q    <= 2'd0;
			step_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						case (q_data.opcode)
							OP_CLEAR: cnt_q <= '0;
							OP_APPEND: if (mem_we) cnt_q <= cnt_q + 1'b1;
							OP_QUERY: begin
								qry_q <= q_data;
								res_q <= '{result_node: q_data.node_id, status: STAT_EMPTY,
									nearest_atom: '0, nearest_distance: '0, potential: '0};
								if (cnt_q == '0) begin
									done_q <= 1'b1;
								end else begin
									r2_q    <= {31'd0, ball_radius} * {31'd0, ball_radius};
									issue_q <= '0;
									ins_q   <= 2'd0;
									state_q <= S_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (issue_go) issue_q <= issue_q + 1'b1;
					// fold one distance into the running minimum
					if (v_s4) begin
						if (sum_s4 < {6'd0, r2_q} && ins_q != 2'd2) ins_q <= ins_q + 2'd1;
						if (idx_s4 == '0 || sum_s4 < best_q) begin
							best_q   <= sum_s4;
							best_i_q <= idx_s4;
							best_c_q <= c_s4;
						end
					end
					if (!issue_go && pipe_empty) begin
						sx_q    <= best_q[63:0];
						sat_q   <= (best_q[67:64] != 4'd0);
						srem_q  <= '0;
						root_q  <= '0;
						step_q  <= 6'd32;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (step_q != '0 && !sat_q) begin
						sx_q   <= {sx_q[61:0], 2'b00};
						step_q <= step_q - 6'd1;
						if (srem_sh >= strial) begin
							srem_q <= srem_sh - strial;
							root_q <= {root_q[30:0], 1'b1};
						end else begin
							srem_q <= srem_sh;
							root_q <= {root_q[30:0], 1'b0};
						end
					end else begin
						// classify the nearest atom
						res_q.nearest_atom     <= 6'(best_i_q);
						res_q.nearest_distance <= sat_q ? 32'hFFFFFFFF : root_q;
						dist_q                 <= sat_q ? 32'hFFFFFFFF : root_q;
						if (ins_q == 2'd2) begin
							res_q.status <= STAT_OVERLAP;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end else if (best_q < {6'd0, r2_q}) begin
							res_q.status <= STAT_INSIDE;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end else if (!sat_q && root_q == '0) begin
							res_q.status    <= STAT_OUTSIDE;
							res_q.potential <= (best_c_q != '0) ? 32'sh80000000 : '0;
							done_q          <= 1'b1;
							state_q         <= S_IDLE;
						end else begin
							res_q.status <= STAT_OUTSIDE;
							num_q        <= {best_c_q, 24'd0};
							drem_q       <= '0;
							quot_q       <= '0;
							step_q       <= 6'd40;
							state_q      <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (step_q != '0) begin
						num_q  <= {num_q[38:0], 1'b0};
						step_q <= step_q - 6'd1;
						if (drem_sh >= {1'b0, dist_q}) begin
							drem_q <= drem_sh - {1'b0, dist_q};
							quot_q <= {quot_q[38:0], 1'b1};
						end else begin
							drem_q <= drem_sh;
							quot_q <= {quot_q[38:0], 1'b0};
						end
					end else begin
						res_q.potential <= $signed(32'(-mag));
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the table never holds more than its depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ATOMS)) else $error("atom count overflow");

	// scan results only arrive while scanning
	a_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> state_q == S_SCAN) else $error("scan data outside scan");

	// root and divide start with a drained pipeline
	a_pipe_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQRT || state_q == S_DIV) |-> pipe_empty)
		else $error("scan pipeline not drained");

	// an overlap report needs two atoms inside the ball
	a_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.status == STAT_OVERLAP) |-> ins_q == 2'd2)
		else $error("overlap without two inside atoms");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nearest_atom_coulomb_bin: requests are driven on
// the start/busy handshake, an in-bench atom table predicts every query
// result, and a monitor compares each done strobe field by field.
// ----------------------------------------------------------------------------
module tb;
	import nacb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	res_t        res;
	logic        cfg_we;
	logic        cfg_index;
	logic [30:0] cfg_data;

	nearest_atom_coulomb_bin i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predictor state
	logic [31:0] tab_x [MAX_ATOMS];
	logic [31:0] tab_y [MAX_ATOMS];
	logic [31:0] tab_z [MAX_ATOMS];
	logic [15:0] tab_nuc [MAX_ATOMS];
	logic [15:0] tab_val [MAX_ATOMS];
	int          tab_count;
	logic [30:0] radius;
	logic        pseudo;

	res_t expected_results[$];
	int   err_count;
	int   n_requests;
	int   n_results;
	int   idle_pct;
	int   idle_cnt;

	function automatic logic [63:0] sq_diff(logic [31:0] a, logic [31:0] b);
		logic signed [32:0] d;
		logic [32:0]        m;
		d = $signed({a[31], a}) - $signed({b[31], b});
		m = d[32] ? -d : d;
		return {31'd0, m} * {31'd0, m};
	endfunction

	function automatic logic [31:0] int_sqrt(logic [63:0] x);
		logic [63:0] r;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			logic [63:0] t;
			t = r | (64'd1 << b);
			if (t * t <= x)
				r = t;
		end
		return r[31:0];
	endfunction

	// compute the answer to one query from the current table
	function automatic res_t predict_query(req_t q);
		res_t        o;
		logic [65:0] s, best, r2;
		logic [63:0] near_d, mag, c;
		int          bi, ins;
		o = '0;
		o.result_node = q.node_id;
		if (tab_count == 0) begin
			o.status = STAT_EMPTY;
			return o;
		end
		r2 = {35'd0, radius} * {35'd0, radius};
		ins = 0;
		bi = 0;
		best = '0;
		for (int i = 0; i < tab_count; i++) begin
			s = 66'(sq_diff(q.pos_x, tab_x[i])) + 66'(sq_diff(q.pos_y, tab_y[i]))
				+ 66'(sq_diff(q.pos_z, tab_z[i]));
			if (s < r2)
				ins++;
			if (i == 0 || s < best) begin
				best = s;
				bi = i;
			end
		end
		near_d = (best[65:64] != 0) ? 64'hFFFF_FFFF : {32'd0, int_sqrt(best[63:0])};
		o.nearest_atom = bi[5:0];
		o.nearest_distance = near_d[31:0];
		if (ins >= 2) begin
			o.status = STAT_OVERLAP;
			return o;
		end
		if (best < r2) begin
			o.status = STAT_INSIDE;
			return o;
		end
		c = pseudo ? tab_val[bi] : tab_nuc[bi];
		if (near_d == 0)
			mag = (c != 0) ? 64'h8000_0000 : 0;
		else
			mag = (c << 24) / near_d;
		if (mag > 64'h8000_0000)
			mag = 64'h8000_0000;
		o.status = STAT_OUTSIDE;
		o.potential = -mag[31:0];
		return o;
	endfunction

	function automatic void apply_request(req_t q);
		case (q.opcode)
			OP_CLEAR: tab_count = 0;
			OP_APPEND: begin
				if (tab_count < MAX_ATOMS) begin
					tab_x[tab_count] = q.pos_x;
					tab_y[tab_count] = q.pos_y;
					tab_z[tab_count] = q.pos_z;
					tab_nuc[tab_count] = q.nuclear_charge;
					tab_val[tab_count] = q.valence_charge;
					tab_count++;
				end
			end
			OP_QUERY: expected_results = {expected_results, predict_query(q)};
			default: ;
		endcase
	endfunction

	// send one request, idling before it at the current rate; start stays
	// high afterwards so back-to-back requests need no gap
	task automatic send_request(req_t q);
		while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req <= q;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_request(q);
		n_requests++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [30:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_BALL_RADIUS)
			radius = v;
		else
			pseudo = v[0];
	endtask

	function automatic req_t mk_req(logic [1:0] op, logic [31:0] x, logic [31:0] y,
		logic [31:0] z, logic [15:0] nc, logic [15:0] vc);
		req_t q;
		q.opcode = op;
		q.node_id = $urandom();
		q.pos_x = x;
		q.pos_y = y;
		q.pos_z = z;
		q.nuclear_charge = nc;
		q.valence_charge = vc;
		return q;
	endfunction

	// coordinate near the origin in Q16.16, occasionally full range
	function automatic logic [31:0] rand_coord();
		if ($urandom_range(9, 0) == 0)
			return $urandom();
		return 32'($signed($urandom_range(40 << 16, 0)) - (20 << 16));
	endfunction

	// directed corners: empty table, extremes, ties, overlap, full table, opcode 3
	task automatic test_directed();
		send_request(mk_req(OP_QUERY, 0, 0, 0, 0, 0));
		send_request(mk_req(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 16'hFFFF));
		send_request(mk_req(OP_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			16'hFFFF, 16'hFFFF));
		send_request(mk_req(OP_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
		send_request(mk_req(OP_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0));
		send_request(mk_req(OP_CLEAR, 0, 0, 0, 0, 0));
		send_request(mk_req(OP_APPEND, 10 << 16, 0, 0, 16'h0100, 16'h0080));
		send_request(mk_req(OP_APPEND, -(10 << 16), 0, 0, 16'h0200, 16'h0000));
		send_request(mk_req(OP_QUERY, 0, 0, 0, 0, 0));
		send_request(mk_req(OP_QUERY, 11 << 16, 0, 0, 0, 0));
		send_request(mk_req(OP_QUERY, 1, 0, 0, 0, 0));
		send_request(mk_req(OP_APPEND, (10 << 16) + 65536, 0, 0, 16'hFFFF, 0));
		send_request(mk_req(OP_QUERY, (10 << 16) + 32768, 0, 0, 0, 0));
		send_request(mk_req(OP_CLEAR, 0, 0, 0, 0, 0));
		for (int i = 0; i < MAX_ATOMS + 2; i++)
			send_request(mk_req(OP_APPEND, rand_coord(), rand_coord(), rand_coord(),
				16'($urandom()), 16'($urandom())));
		send_request(mk_req(OP_QUERY, rand_coord(), rand_coord(), rand_coord(), 0, 0));
	endtask

	// radius 0 and pseudopotential corners
	task automatic test_zero_radius();
		write_cfg(CFG_BALL_RADIUS, 31'd0);
		write_cfg(CFG_USE_PSEUDO, 31'd1);
		send_request(mk_req(OP_CLEAR, 0, 0, 0, 0, 0));
		send_request(mk_req(OP_APPEND, 5, 5, 5, 16'h0100, 16'h0000));
		send_request(mk_req(OP_APPEND, 6, 5, 5, 16'h0100, 16'hFFFF));
		send_request(mk_req(OP_QUERY, 5, 5, 5, 0, 0));
		send_request(mk_req(OP_QUERY, 6, 5, 5, 0, 0));
		send_request(mk_req(OP_QUERY, 7, 5, 5, 0, 0));
		write_cfg(CFG_BALL_RADIUS, 31'h7FFF_FFFF);
		send_request(mk_req(OP_QUERY, 7, 5, 5, 0, 0));
	endtask

	// well-formed table builds followed by queries, with random noise
	task automatic test_random(int n);
		int k, nat;
		k = 0;
		while (k < n) begin
			if ($urandom_range(9, 0) == 0) begin
				send_request(mk_req(2'($urandom()), $urandom(), $urandom(), $urandom(),
					16'($urandom()), 16'($urandom())));
				k++;
				continue;
			end
			send_request(mk_req(OP_CLEAR, 0, 0, 0, 0, 0));
			nat = ($urandom_range(15, 0) == 0) ? $urandom_range(70, 1)
				: $urandom_range(6, 1);
			for (int i = 0; i < nat; i++)
				send_request(mk_req(OP_APPEND, rand_coord(), rand_coord(), rand_coord(),
					16'($urandom()), 16'($urandom())));
			for (int i = 0; i < 4; i++)
				send_request(mk_req(OP_QUERY, rand_coord(), rand_coord(),
					rand_coord(), 0, 0));
			k += nat + 5;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			n_results++;
			if (expected_results.size() == 0) begin
				$error("unexpected result node=%h", res.result_node);
				err_count++;
			end else begin
				e = expected_results.pop_front();
				if (res.result_node !== e.result_node) begin
					$error("result_node exp %h got %h", e.result_node, res.result_node);
					err_count++;
				end
				if (res.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, res.status);
					err_count++;
				end
				if (res.nearest_atom !== e.nearest_atom) begin
					$error("nearest_atom exp %0d got %0d", e.nearest_atom, res.nearest_atom);
					err_count++;
				end
				if (res.nearest_distance !== e.nearest_distance) begin
					$error("nearest_distance exp %h got %h", e.nearest_distance,
						res.nearest_distance);
					err_count++;
				end
				if (res.potential !== e.potential) begin
					$error("potential exp %h got %h", e.potential, res.potential);
					err_count++;
				end
			end
		end
	end

	// watchdog: cycles without any accepted request, result or configuration write
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt > 20000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_BALL_RADIUS;
		cfg_data = '0;
		idle_cnt = 0;
		err_count = 0;
		n_requests = 0;
		n_results = 0;
		idle_pct = 0;
		tab_count = 0;
		radius = BALL_RADIUS_RST;
		pseudo = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_zero_radius();
		write_cfg(CFG_BALL_RADIUS, BALL_RADIUS_RST);
		write_cfg(CFG_USE_PSEUDO, 31'd0);
		idle_pct = 0;
		test_random(120);
		idle_pct = 66;
		write_cfg(CFG_BALL_RADIUS, 31'd1 << 18 + 1);
		test_random(100);
		idle_pct = 8;
		write_cfg(CFG_USE_PSEUDO, 31'd1);
		write_cfg(CFG_BALL_RADIUS, 31'd65536);
		test_random(100);
		wait_drained();

		$display("Covered %0d requests and %0d query results over several radius",
			n_requests, n_results);
		$display("and charge-mode settings with varied request pacing.");
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/nacb_pkg.sv
hw/rtl/nacb_front.sv
hw/rtl/nacb_queue.sv
hw/rtl/nacb_back.sv
hw/rtl/nearest_atom_coulomb_bin.sv
tb/tb.sv
